// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KVZ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define KVZ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle rule");

`endif

// File: hw/rtl/kvz_pkg.sv
// Types and constants of the key and velocity zone selector.
`default_nettype none
package kvz_pkg;

   // Table geometry.
   localparam int ZONE_IDX_W = 6;
   localparam int COUNT_W    = 7;
   localparam logic [COUNT_W-1:0] MAX_ZONES = 7'd64;

   // Request function codes.
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Match level codes.
   localparam logic [1:0] LEVEL_BOTH = 2'd0;
   localparam logic [1:0] LEVEL_KEY  = 2'd1;
   localparam logic [1:0] LEVEL_ANY  = 2'd2;

   // One stored zone.
   typedef struct packed {
      logic [6:0] key_low;
      logic [6:0] key_high;
      logic [6:0] vel_low;
      logic [6:0] vel_high;
   } zone_type;

   // Outcome of checking one zone against a note.
   typedef struct packed {
      logic key_ok;
      logic both_ok;
   } match_type;

endpackage
`default_nettype wire

// File: hw/rtl/kvz_ifs.sv
// Channel interfaces: request, response and register write.
`default_nettype none

interface kvz_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [5:0] zone_index;
   logic [6:0] key_low;
   logic [6:0] key_high;
   logic [6:0] vel_low;
   logic [6:0] vel_high;
   logic [7:0] note_key;
   logic [7:0] note_velocity;
   modport source (output valid, func, zone_index, key_low, key_high, vel_low, vel_high,
                   note_key, note_velocity, input ready);
   modport sink (input valid, func, zone_index, key_low, key_high, vel_low, vel_high,
                 note_key, note_velocity, output ready);
endinterface

interface kvz_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [5:0] chosen_zone;
   logic [1:0] match_level;
   modport source (output valid, found, chosen_zone, match_level, input ready);
   modport sink (input valid, found, chosen_zone, match_level, output ready);
endinterface

interface kvz_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/key_velocity_zone_select.sv
// Top level of the key and velocity zone selector.
//
//   channel   dir  handshake      carries
//   req_chan  in   valid/ready    write of one zone, or a note lookup
//   rsp_chan  out  valid/ready    found, chosen_zone, match_level
//   csr_chan  in   valid/ready    zone_count (always ready)
//
// A lookup scans the table once, one zone per cycle through the shared range
// compare unit, over zone_count zones clipped to 64, and then loads the response
// register; a write skips the scan and loads the response register directly.
// One request is in work at a time; a finished response waits in the output
// register while the next request is taken. Reset clears zone_count and the
// control state; the zone table has no reset.
`default_nettype none
module key_velocity_zone_select (
   input  logic         clock,
   input  logic         reset,
   kvz_req_if.sink      req_chan,
   kvz_rsp_if.source    rsp_chan,
   kvz_csr_if.sink      csr_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;

   kvz_pkg::zone_type zone_mem [kvz_pkg::MAX_ZONES];
   kvz_pkg::zone_type rd_zone_ff;

   logic [kvz_pkg::COUNT_W-1:0]    zone_count_ff;
   logic [kvz_pkg::COUNT_W-1:0]    limit_ff;
   logic [kvz_pkg::COUNT_W-1:0]    idx_ff;
   logic                           cmp_vld_ff;
   logic [kvz_pkg::ZONE_IDX_W-1:0] cmp_idx_ff;
   logic                           func_ff;
   logic [7:0]                     key_ff;
   logic [7:0]                     vel_ff;
   logic                           hit_both_ff;
   logic [kvz_pkg::ZONE_IDX_W-1:0] idx_both_ff;
   logic                           hit_key_ff;
   logic [kvz_pkg::ZONE_IDX_W-1:0] idx_key_ff;
   logic                           rsp_valid_ff;
   logic                           found_ff;
   logic [kvz_pkg::ZONE_IDX_W-1:0] zone_ff;
   logic [1:0]                     level_ff;

   logic                           req_fire;
   logic                           rsp_load;
   logic [kvz_pkg::COUNT_W-1:0]    limit_in;
   kvz_pkg::match_type             cmp_res;

   assign req_fire = req_chan.valid && req_chan.ready;

   // A finished request loads the response register once it is free or being taken.
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // Handshake outputs.
   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = found_ff;
   assign rsp_chan.chosen_zone = zone_ff;
   assign rsp_chan.match_level = level_ff;

   // Zone count clipped to the table depth.
   assign limit_in = (zone_count_ff > kvz_pkg::MAX_ZONES) ? kvz_pkg::MAX_ZONES : zone_count_ff;

   // Zone count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_count_ff <= '0;
      end else if (csr_chan.valid) begin
         zone_count_ff <= csr_chan.data;
      end
   end

   // Zone table: written by a write request, read one slot per scan cycle.
   always_ff @(posedge clock) begin
      if (req_fire && (req_chan.func == kvz_pkg::FUNC_WRITE)) begin
         zone_mem[req_chan.zone_index] <= '{key_low:  req_chan.key_low,
                                            key_high: req_chan.key_high,
                                            vel_low:  req_chan.vel_low,
                                            vel_high: req_chan.vel_high};
      end
      rd_zone_ff <= zone_mem[idx_ff[kvz_pkg::ZONE_IDX_W-1:0]];
   end

   // Shared range compare unit, fed from the registered table read.
   kvz_match u_match (
      .zone          (rd_zone_ff),
      .note_key      (key_ff),
      .note_velocity (vel_ff),
      .result        (cmp_res)
   );

   // Sequencer, first-match trackers and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         hit_both_ff  <= 1'b0;
         hit_key_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The response leaves when the sink takes it, unless a new one replaces it.
         if (rsp_valid_ff && rsp_chan.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         // Track the first zone of each kind seen by the compare unit.
         if (cmp_vld_ff) begin
            if (cmp_res.both_ok && !hit_both_ff) begin
               hit_both_ff <= 1'b1;
               idx_both_ff <= cmp_idx_ff;
            end
            if (cmp_res.key_ok && !hit_key_ff) begin
               hit_key_ff <= 1'b1;
               idx_key_ff <= cmp_idx_ff;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               cmp_vld_ff <= 1'b0;
               if (req_fire) begin
                  func_ff     <= req_chan.func;
                  key_ff      <= req_chan.note_key;
                  vel_ff      <= req_chan.note_velocity;
                  limit_ff    <= limit_in;
                  idx_ff      <= '0;
                  hit_both_ff <= 1'b0;
                  hit_key_ff  <= 1'b0;
                  state_ff    <= (req_chan.func == kvz_pkg::FUNC_LOOKUP) ? ST_SCAN : ST_FINISH;
               end
            end
            ST_SCAN: begin
               // Issue one table read per cycle until the zone count is reached.
               if (idx_ff < limit_ff) begin
                  cmp_vld_ff <= 1'b1;
                  cmp_idx_ff <= idx_ff[kvz_pkg::ZONE_IDX_W-1:0];
                  idx_ff     <= idx_ff + 7'd1;
               end else begin
                  cmp_vld_ff <= 1'b0;
                  state_ff   <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // The trackers already hold the last compare; no compare is in flight here.
               cmp_vld_ff <= 1'b0;
               state_ff   <= ST_FINISH;
            end
            ST_FINISH: begin
               cmp_vld_ff <= 1'b0;
               if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if ((func_ff == kvz_pkg::FUNC_LOOKUP) && hit_both_ff) begin
                     found_ff <= 1'b1;
                     zone_ff  <= idx_both_ff;
                     level_ff <= kvz_pkg::LEVEL_BOTH;
                  end else if ((func_ff == kvz_pkg::FUNC_LOOKUP) && hit_key_ff &&
                               (vel_ff != 8'd0)) begin
                     found_ff <= 1'b1;
                     zone_ff  <= idx_key_ff;
                     level_ff <= kvz_pkg::LEVEL_KEY;
                  end else if ((func_ff == kvz_pkg::FUNC_LOOKUP) && (key_ff != 8'd0) &&
                               (limit_ff != '0)) begin
                     // Fallback to the first zone of the table.
                     found_ff <= 1'b1;
                     zone_ff  <= '0;
                     level_ff <= kvz_pkg::LEVEL_ANY;
                  end else begin
                     found_ff <= 1'b0;
                     zone_ff  <= '0;
                     level_ff <= kvz_pkg::LEVEL_BOTH;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/kvz_match.sv
// Range compare unit: checks one zone against the note key and velocity.
`default_nettype none
module kvz_match (
   input  kvz_pkg::zone_type  zone,
   input  logic [7:0]         note_key,
   input  logic [7:0]         note_velocity,
   output kvz_pkg::match_type result
);

   logic key_in;
   logic vel_in;

   // A zero key or velocity matches any range; values above 127 match none.
   assign key_in = (note_key == 8'd0) ||
                   (({1'b0, zone.key_low} <= note_key) && (note_key <= {1'b0, zone.key_high}));
   assign vel_in = (note_velocity == 8'd0) ||
                   (({1'b0, zone.vel_low} <= note_velocity) &&
                    (note_velocity <= {1'b0, zone.vel_high}));

   assign result.key_ok  = key_in;
   assign result.both_ok = key_in && vel_in;

endmodule
`default_nettype wire

// File: hw/rtl/kvz_checker.sv
// Port-level checker for the zone selector, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module kvz_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       found,
   input logic [5:0] chosen_zone,
   input logic [1:0] match_level
);

   // A response waits until it is taken.
   `KVZ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // One request at a time: the block is busy right after it takes one.
   `KVZ_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // A response without a zone carries zero index and level.
   `KVZ_ASSERT_NOW(a_not_found_zero, clock, reset, rsp_valid && !found,
                   chosen_zone == 6'd0 && match_level == kvz_pkg::LEVEL_BOTH)

   // The fallback always names the first zone.
   `KVZ_ASSERT_NOW(a_any_is_first, clock, reset, rsp_valid && match_level == kvz_pkg::LEVEL_ANY,
                   found && chosen_zone == 6'd0)

   // Only the three defined levels appear.
   `KVZ_ASSERT_NOW(a_level_code, clock, reset, rsp_valid,
                   match_level == kvz_pkg::LEVEL_BOTH || match_level == kvz_pkg::LEVEL_KEY ||
                   match_level == kvz_pkg::LEVEL_ANY)

endmodule

bind key_velocity_zone_select kvz_checker u_kvz_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .found       (rsp_chan.found),
   .chosen_zone (rsp_chan.chosen_zone),
   .match_level (rsp_chan.match_level)
);
`default_nettype wire
